// ----- hdl/fmm_pkg.sv -----
`default_nettype none

package fmm_pkg;

  localparam int FMM_MAX_DIM = 64;

  localparam logic [31:0] FP_ZERO     = 32'h0000_0000;
  localparam logic [31:0] FP_ONE      = 32'h3F80_0000;
  localparam logic [31:0] FP_DEF_NAN  = 32'hFFC0_0000;
  localparam logic [31:0] FP_QUIET    = 32'h0040_0000;

  typedef enum logic [2:0] {
    REQ_WR_A    = 3'd0,
    REQ_WR_B    = 3'd1,
    REQ_WR_C    = 3'd2,
    REQ_COMPUTE = 3'd3,
    REQ_RD_C    = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    REG_TRANS_A = 3'd0,
    REG_TRANS_B = 3'd1,
    REG_ROWS_M  = 3'd2,
    REG_COLS_N  = 3'd3,
    REG_INNER_K = 3'd4,
    REG_ALPHA   = 3'd5,
    REG_BETA    = 3'd6
  } reg_idx_t;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic        trans_a;
    logic        trans_b;
    logic [6:0]  rows_m;
    logic [6:0]  cols_n;
    logic [6:0]  inner_k;
    logic [31:0] alpha_bits;
    logic [31:0] beta_bits;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
  } fp_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } fp_rsp_t;

  typedef struct packed {
    logic        push;
    logic        kind;
    logic [31:0] value;
  } res_t;

  function automatic logic fp_is_nan(input logic [31:0] x);
    return (&x[30:23]) & (|x[22:0]);
  endfunction

  function automatic logic fp_is_inf(input logic [31:0] x);
    return (&x[30:23]) & ~(|x[22:0]);
  endfunction

  function automatic logic fp_is_zero(input logic [31:0] x);
    return ~(|x[30:0]);
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd48;
    found = 1'b0;
    for (int b = 47; b >= 0; b--) begin
      if (!found && v[b]) begin
        n     = 6'(47 - b);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // sig holds 1.x in bit 26, 23 fraction bits, then guard, round, sticky.
  // ex is the biased exponent of bit 26; below 1 the value goes subnormal.
  function automatic logic [31:0] round_pack(input logic sign,
                                             input logic signed [11:0] ex,
                                             input logic [26:0] sig);
    logic [11:0] sh;
    logic [26:0] s;
    logic [26:0] mask;
    logic [7:0]  ef;
    logic        inc;
    logic [30:0] body;
    logic [31:0] r;
    sh   = 12'(12'sd1 - ex);
    s    = sig;
    ef   = ex[7:0];
    mask = '0;
    if (ex >= 12'sd255) begin
      r = {sign, 8'hFF, 23'd0};
    end else begin
      if (ex <= 12'sd0) begin
        ef = 8'd0;
        if (sh > 12'd26) begin
          s = {26'd0, |sig};
        end else begin
          mask = ~(27'h7FF_FFFF << sh[4:0]);
          s    = (sig >> sh[4:0]) | {26'd0, |(sig & mask)};
        end
      end
      inc  = s[2] & (s[1] | s[0] | s[3]);
      body = {ef, s[25:3]} + {30'd0, inc};
      r    = {sign, body};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/float_matrix_multiply_accumulate.sv -----
`default_nettype none

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   req_type, row_index, col_index, elem_value
// out_      output     out_valid / out_stall result_kind, read_value
// cfg_      APB slave  psel/penable/pwrite   7 registers at byte address 4*i, 32-bit data
//
// A read of C reads the C memory, waits in ST_RDC and is then registered at out_; the
// input stays stalled until the result is handed over.
// A compute transaction runs a single multiplier and a single adder,
// one operation at a time.
// The next transaction is taken once the previous one has handed its result to out_.
// Reset is synchronous; it clears control and configuration, not the matrix memories.
// out_stall holds the result register; while a result waits, the next transaction that
// answers is taken and then holds the input.
module float_matrix_multiply_accumulate import fmm_pkg::*; #(
  parameter int MAX_DIM = FMM_MAX_DIM
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [5:0]  in_row_index,
  input  logic [5:0]  in_col_index,
  input  logic [31:0] in_elem_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [31:0] out_read_value,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic        trans_a_r, trans_b_r;
  logic [6:0]  rows_m_r, cols_n_r, inner_k_r;
  logic [31:0] alpha_r, beta_r;
  logic        out_valid_r;
  logic        out_kind_r;
  logic [31:0] out_value_r;
  logic        cfg_wr;
  logic [2:0]  reg_sel;
  cfg_t        cfg;
  res_t        res;
  logic        res_free;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_a_r <= 1'b0;
      trans_b_r <= 1'b0;
      rows_m_r  <= 7'd0;
      cols_n_r  <= 7'd0;
      inner_k_r <= 7'd0;
      alpha_r   <= FP_ONE;
      beta_r    <= FP_ZERO;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_TRANS_A: trans_a_r <= cfg_pwdata[0];
        REG_TRANS_B: trans_b_r <= cfg_pwdata[0];
        REG_ROWS_M:  rows_m_r  <= cfg_pwdata[6:0];
        REG_COLS_N:  cols_n_r  <= cfg_pwdata[6:0];
        REG_INNER_K: inner_k_r <= cfg_pwdata[6:0];
        REG_ALPHA:   alpha_r   <= cfg_pwdata;
        REG_BETA:    beta_r    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TRANS_A: cfg_prdata = {31'd0, trans_a_r};
      REG_TRANS_B: cfg_prdata = {31'd0, trans_b_r};
      REG_ROWS_M:  cfg_prdata = {25'd0, rows_m_r};
      REG_COLS_N:  cfg_prdata = {25'd0, cols_n_r};
      REG_INNER_K: cfg_prdata = {25'd0, inner_k_r};
      REG_ALPHA:   cfg_prdata = alpha_r;
      REG_BETA:    cfg_prdata = beta_r;
      default:     cfg_prdata = 32'd0;
    endcase
  end

  assign cfg = '{trans_a: trans_a_r, trans_b: trans_b_r, rows_m: rows_m_r,
                 cols_n: cols_n_r, inner_k: inner_k_r,
                 alpha_bits: alpha_r, beta_bits: beta_r};

  assign res_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res.push) begin
      out_kind_r  <= res.kind;
      out_value_r <= res.value;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_read_value  = out_value_r;

  fmm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_elem_value(in_elem_value),
    .cfg          (cfg),
    .res_free     (res_free),
    .res          (res)
  );

endmodule

`default_nettype wire

// ----- hdl/fmm_ram.sv -----
`default_nettype none

module fmm_ram #(
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/fmm_fmul.sv -----
`default_nettype none

module fmm_fmul import fmm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  fp_req_t req,
  output fp_rsp_t rsp
);

  logic               v1_r, v2_r, v3_r;
  logic               spec1_r, spec2_r;
  logic [31:0]        sval1_r, sval2_r;
  logic               sign1_r, sign2_r;
  logic signed [11:0] e1_r, e2_r;
  logic [47:0]        p1_r, p2_r;
  logic [5:0]         lz2_r;
  logic [31:0]        res_r;

  logic [7:0]         ea, eb;
  logic [23:0]        ma, mb;
  logic               sgn;
  logic               spec;
  logic [31:0]        sval;
  logic [47:0]        pn;
  logic signed [11:0] ex3;

  assign ea  = (req.a[30:23] == 8'd0) ? 8'd1 : req.a[30:23];
  assign eb  = (req.b[30:23] == 8'd0) ? 8'd1 : req.b[30:23];
  assign ma  = {|req.a[30:23], req.a[22:0]};
  assign mb  = {|req.b[30:23], req.b[22:0]};
  assign sgn = req.a[31] ^ req.b[31];

  always_comb begin
    spec = 1'b1;
    sval = FP_ZERO;
    priority if (fp_is_nan(req.a)) begin
      sval = req.a | FP_QUIET;
    end else if (fp_is_nan(req.b)) begin
      sval = req.b | FP_QUIET;
    end else if ((fp_is_inf(req.a) && fp_is_zero(req.b)) ||
                 (fp_is_zero(req.a) && fp_is_inf(req.b))) begin
      sval = FP_DEF_NAN;
    end else if (fp_is_inf(req.a) || fp_is_inf(req.b)) begin
      sval = {sgn, 8'hFF, 23'd0};
    end else if (fp_is_zero(req.a) || fp_is_zero(req.b)) begin
      sval = {sgn, 31'd0};
    end else begin
      spec = 1'b0;
    end
  end

  // stage 1: multiply, stage 2: count leading zeros, stage 3: normalize and round
  always_ff @(posedge clk) begin
    p1_r    <= ma * mb;
    e1_r    <= $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd127;
    sign1_r <= sgn;
    spec1_r <= spec;
    sval1_r <= sval;
    p2_r    <= p1_r;
    e2_r    <= e1_r;
    sign2_r <= sign1_r;
    spec2_r <= spec1_r;
    sval2_r <= sval1_r;
    lz2_r   <= lzc48(p1_r);
    res_r   <= spec2_r ? sval2_r : round_pack(sign2_r, ex3, {pn[47:22], |pn[21:0]});
  end

  assign pn  = p2_r << lz2_r;
  assign ex3 = e2_r + 12'sd1 - $signed({6'd0, lz2_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= req.start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign rsp.done = v3_r;
  assign rsp.res  = res_r;

endmodule

`default_nettype wire

// ----- hdl/fmm_fadd.sv -----
`default_nettype none

module fmm_fadd import fmm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  fp_req_t req,
  output fp_rsp_t rsp
);

  logic        v1_r, v2_r, v3_r, v4_r;
  logic        spec1_r, spec2_r, spec3_r;
  logic [31:0] sval1_r, sval2_r, sval3_r;
  logic        sign1_r, sign2_r, sign3_r;
  logic        zsgn1_r, zsgn2_r, zsgn3_r;
  logic        sub1_r;
  logic [7:0]  e1_r, e2_r, e3_r;
  logic [26:0] ml1_r, ms1_r;
  logic [27:0] sum2_r, sum3_r;
  logic [5:0]  lz3_r;
  logic [31:0] res_r;

  logic        swap;
  logic [31:0] lg, sm;
  logic [7:0]  el, es, d;
  logic [26:0] ml, msr, msal, mask;
  logic        spec;
  logic [31:0] sval;
  logic [27:0] sn;
  logic signed [11:0] ex4;

  assign swap = req.b[30:0] > req.a[30:0];
  assign lg   = swap ? req.b : req.a;
  assign sm   = swap ? req.a : req.b;
  assign el   = (lg[30:23] == 8'd0) ? 8'd1 : lg[30:23];
  assign es   = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
  assign d    = el - es;
  assign ml   = {|lg[30:23], lg[22:0], 3'd0};
  assign msr  = {|sm[30:23], sm[22:0], 3'd0};

  always_comb begin
    mask = '0;
    if (d > 8'd26) begin
      msal = {26'd0, |msr};
    end else begin
      mask = ~(27'h7FF_FFFF << d[4:0]);
      msal = (msr >> d[4:0]) | {26'd0, |(msr & mask)};
    end
  end

  always_comb begin
    spec = 1'b1;
    sval = FP_ZERO;
    priority if (fp_is_nan(req.a)) begin
      sval = req.a | FP_QUIET;
    end else if (fp_is_nan(req.b)) begin
      sval = req.b | FP_QUIET;
    end else if (fp_is_inf(req.a) && fp_is_inf(req.b) && (req.a[31] != req.b[31])) begin
      sval = FP_DEF_NAN;
    end else if (fp_is_inf(req.a)) begin
      sval = req.a;
    end else if (fp_is_inf(req.b)) begin
      sval = req.b;
    end else begin
      spec = 1'b0;
    end
  end

  // stage 1: align, 2: add, 3: count leading zeros, 4: normalize and round
  always_ff @(posedge clk) begin
    ml1_r   <= ml;
    ms1_r   <= msal;
    e1_r    <= el;
    sub1_r  <= req.a[31] ^ req.b[31];
    sign1_r <= lg[31];
    zsgn1_r <= req.a[31] & req.b[31];
    spec1_r <= spec;
    sval1_r <= sval;

    sum2_r  <= sub1_r ? ({1'b0, ml1_r} - {1'b0, ms1_r}) : ({1'b0, ml1_r} + {1'b0, ms1_r});
    e2_r    <= e1_r;
    sign2_r <= sign1_r;
    zsgn2_r <= zsgn1_r;
    spec2_r <= spec1_r;
    sval2_r <= sval1_r;

    lz3_r   <= lzc48({sum2_r, 20'd0});
    sum3_r  <= sum2_r;
    e3_r    <= e2_r;
    sign3_r <= sign2_r;
    zsgn3_r <= zsgn2_r;
    spec3_r <= spec2_r;
    sval3_r <= sval2_r;

    if (spec3_r) begin
      res_r <= sval3_r;
    end else if (sum3_r == 28'd0) begin
      res_r <= {zsgn3_r, 31'd0};
    end else begin
      res_r <= round_pack(sign3_r, ex4, {sn[27:2], |sn[1:0]});
    end
  end

  assign sn  = sum3_r << lz3_r[4:0];
  assign ex4 = $signed({4'd0, e3_r}) + 12'sd1 - $signed({6'd0, lz3_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= req.start;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign rsp.done = v4_r;
  assign rsp.res  = res_r;

endmodule

`default_nettype wire

// ----- hdl/fmm_ctrl.sv -----
`default_nettype none

module fmm_ctrl import fmm_pkg::*; #(
  parameter int MAX_DIM = FMM_MAX_DIM
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [5:0]  in_row_index,
  input  logic [5:0]  in_col_index,
  input  logic [31:0] in_elem_value,
  input  cfg_t        cfg,
  input  logic        res_free,
  output res_t        res
);

  localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW = 2 * DW;
  localparam int XW = ($clog2(MAX_DIM + 1) > 7) ? $clog2(MAX_DIM + 1) : 7;
  localparam int IW = 6;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RDC, ST_DONE,
    ST_SC_RD, ST_SC_MUL, ST_SC_WB,
    ST_NB_RD, ST_NB_CHK, ST_NB_TW,
    ST_NA_RD, ST_NA_MUL, ST_NA_MW, ST_NA_AW,
    ST_TL_RD, ST_TL_MUL, ST_TL_MW, ST_TL_AW,
    ST_TF_RD, ST_TF_AM, ST_TF_BM, ST_TF_AW
  } state_t;

  state_t        state_r, state_nxt;
  logic [DW-1:0] i_r, i_nxt, j_r, j_nxt, l_r, l_nxt;
  logic [31:0]   t_r, t_nxt, c_r, c_nxt, d_r, d_nxt, ad_r, ad_nxt;
  logic          rd_in_r, rd_in_nxt;

  logic [IW+DW-1:0] row_ext, col_ext;
  logic [DW-1:0]    row_idx, col_idx;
  logic             in_range, accept;
  logic [AW-1:0]    in_addr, c_ij, a_raddr, b_raddr, c_addr;

  logic [XW-1:0] m_sat, n_sat, k_sat, m_m1, n_m1, k_m1;
  logic [DW-1:0] m_last, n_last, k_last;
  logic          alpha0, beta0, beta1, k0, skip;
  logic          i_end, j_end, l_end;

  logic          a_we, b_we, c_we, a_re, b_re, c_re;
  logic [31:0]   c_wdata, a_rdata, b_rdata, c_rdata;
  fp_req_t       mul_req, add_req;
  fp_rsp_t       mul_rsp, add_rsp;

  assign row_ext  = {{DW{1'b0}}, in_row_index};
  assign col_ext  = {{DW{1'b0}}, in_col_index};
  assign row_idx  = row_ext[DW-1:0];
  assign col_idx  = col_ext[DW-1:0];
  assign in_range = (XW'(in_row_index) < XW'(MAX_DIM)) && (XW'(in_col_index) < XW'(MAX_DIM));

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  assign m_sat  = (XW'(cfg.rows_m) > XW'(MAX_DIM)) ? XW'(MAX_DIM) : XW'(cfg.rows_m);
  assign n_sat  = (XW'(cfg.cols_n) > XW'(MAX_DIM)) ? XW'(MAX_DIM) : XW'(cfg.cols_n);
  assign k_sat  = (XW'(cfg.inner_k) > XW'(MAX_DIM)) ? XW'(MAX_DIM) : XW'(cfg.inner_k);
  assign m_m1   = m_sat - XW'(1);
  assign n_m1   = n_sat - XW'(1);
  assign k_m1   = k_sat - XW'(1);
  assign m_last = m_m1[DW-1:0];
  assign n_last = n_m1[DW-1:0];
  assign k_last = k_m1[DW-1:0];

  assign alpha0 = fp_is_zero(cfg.alpha_bits);
  assign beta0  = fp_is_zero(cfg.beta_bits);
  assign beta1  = (cfg.beta_bits == FP_ONE);
  assign k0     = (k_sat == '0);
  assign skip   = (m_sat == '0) || (n_sat == '0) || ((alpha0 || k0) && beta1);

  assign i_end = (i_r == m_last);
  assign j_end = (j_r == n_last);
  assign l_end = (l_r == k_last);

  assign in_addr = {row_idx, col_idx};
  assign c_ij    = {i_r, j_r};
  assign a_raddr = cfg.trans_a ? {l_r, i_r} : {i_r, l_r};
  assign b_raddr = cfg.trans_b ? {j_r, l_r} : {l_r, j_r};
  assign c_addr  = (state_r == ST_IDLE) ? in_addr : c_ij;

  assign a_we = accept && (in_req_type == REQ_WR_A) && in_range;
  assign b_we = accept && (in_req_type == REQ_WR_B) && in_range;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    l_nxt     = l_r;
    t_nxt     = t_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    ad_nxt    = ad_r;
    rd_in_nxt = rd_in_r;
    a_re      = 1'b0;
    b_re      = 1'b0;
    c_re      = 1'b0;
    c_we      = 1'b0;
    c_wdata   = in_elem_value;
    mul_req   = '{start: 1'b0, a: 32'd0, b: 32'd0};
    add_req   = '{start: 1'b0, a: 32'd0, b: 32'd0};
    res       = '{push: 1'b0, kind: KIND_DONE, value: 32'd0};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          i_nxt = '0;
          j_nxt = '0;
          l_nxt = '0;
          d_nxt = FP_ZERO;
          priority if (in_req_type == REQ_WR_C) begin
            c_we = in_range;
          end else if (in_req_type == REQ_RD_C) begin
            c_re      = in_range;
            rd_in_nxt = in_range;
            state_nxt = ST_RDC;
          end else if (in_req_type == REQ_COMPUTE) begin
            priority if (skip) state_nxt = ST_DONE;
            else if (alpha0 || (!cfg.trans_a && !beta1)) state_nxt = ST_SC_RD;
            else if (!cfg.trans_a) state_nxt = ST_NB_RD;
            else if (k0) state_nxt = ST_TF_RD;
            else state_nxt = ST_TL_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_RDC: begin
        res = '{push: res_free, kind: KIND_READ, value: rd_in_r ? c_rdata : 32'd0};
        if (res_free) state_nxt = ST_IDLE;
      end

      ST_DONE: begin
        res = '{push: res_free, kind: KIND_DONE, value: 32'd0};
        if (res_free) state_nxt = ST_IDLE;
      end

      // scale pass over one column of C
      ST_SC_RD: begin
        c_re      = 1'b1;
        state_nxt = ST_SC_MUL;
      end

      ST_SC_MUL, ST_SC_WB: begin
        if (state_r == ST_SC_MUL && !beta0) begin
          mul_req   = '{start: 1'b1, a: c_rdata, b: cfg.beta_bits};
          state_nxt = ST_SC_WB;
        end else if (state_r == ST_SC_MUL || mul_rsp.done) begin
          c_we    = 1'b1;
          c_wdata = (state_r == ST_SC_MUL) ? FP_ZERO : mul_rsp.res;
          if (!i_end) begin
            i_nxt     = i_r + DW'(1);
            state_nxt = ST_SC_RD;
          end else begin
            i_nxt = '0;
            if (alpha0 || k0) begin
              if (j_end) begin
                state_nxt = ST_DONE;
              end else begin
                j_nxt     = j_r + DW'(1);
                state_nxt = ST_SC_RD;
              end
            end else begin
              l_nxt     = '0;
              state_nxt = ST_NB_RD;
            end
          end
        end
      end

      ST_NB_RD: begin
        b_re      = 1'b1;
        state_nxt = ST_NB_CHK;
      end

      ST_NB_CHK, ST_NA_AW: begin
        if (state_r == ST_NB_CHK && !fp_is_zero(b_rdata)) begin
          mul_req   = '{start: 1'b1, a: cfg.alpha_bits, b: b_rdata};
          state_nxt = ST_NB_TW;
        end else if (state_r == ST_NA_AW && !add_rsp.done) begin
          state_nxt = ST_NA_AW;
        end else if (state_r == ST_NA_AW && !i_end) begin
          c_we      = 1'b1;
          c_wdata   = add_rsp.res;
          i_nxt     = i_r + DW'(1);
          state_nxt = ST_NA_RD;
        end else begin
          // next inner index, then next column
          c_we    = (state_r == ST_NA_AW);
          c_wdata = add_rsp.res;
          i_nxt   = '0;
          if (!l_end) begin
            l_nxt     = l_r + DW'(1);
            state_nxt = ST_NB_RD;
          end else begin
            l_nxt = '0;
            if (j_end) begin
              state_nxt = ST_DONE;
            end else begin
              j_nxt     = j_r + DW'(1);
              state_nxt = beta1 ? ST_NB_RD : ST_SC_RD;
            end
          end
        end
      end

      ST_NB_TW: begin
        if (mul_rsp.done) begin
          t_nxt     = mul_rsp.res;
          i_nxt     = '0;
          state_nxt = ST_NA_RD;
        end
      end

      ST_NA_RD: begin
        a_re      = 1'b1;
        c_re      = 1'b1;
        state_nxt = ST_NA_MUL;
      end

      ST_NA_MUL: begin
        c_nxt     = c_rdata;
        mul_req   = '{start: 1'b1, a: t_r, b: a_rdata};
        state_nxt = ST_NA_MW;
      end

      ST_NA_MW: begin
        if (mul_rsp.done) begin
          add_req   = '{start: 1'b1, a: c_r, b: mul_rsp.res};
          state_nxt = ST_NA_AW;
        end
      end

      // dot product for one element of C
      ST_TL_RD: begin
        a_re      = 1'b1;
        b_re      = 1'b1;
        state_nxt = ST_TL_MUL;
      end

      ST_TL_MUL: begin
        mul_req   = '{start: 1'b1, a: a_rdata, b: b_rdata};
        state_nxt = ST_TL_MW;
      end

      ST_TL_MW: begin
        if (mul_rsp.done) begin
          add_req   = '{start: 1'b1, a: d_r, b: mul_rsp.res};
          state_nxt = ST_TL_AW;
        end
      end

      ST_TL_AW: begin
        if (add_rsp.done) begin
          d_nxt = add_rsp.res;
          if (!l_end) begin
            l_nxt     = l_r + DW'(1);
            state_nxt = ST_TL_RD;
          end else begin
            l_nxt     = '0;
            state_nxt = ST_TF_RD;
          end
        end
      end

      ST_TF_RD: begin
        c_re      = 1'b1;
        mul_req   = '{start: 1'b1, a: cfg.alpha_bits, b: d_r};
        state_nxt = ST_TF_AM;
      end

      ST_TF_BM: begin
        if (mul_rsp.done) begin
          add_req   = '{start: 1'b1, a: ad_r, b: mul_rsp.res};
          state_nxt = ST_TF_AW;
        end
      end

      ST_TF_AM, ST_TF_AW: begin
        if (state_r == ST_TF_AM && mul_rsp.done && !beta0) begin
          ad_nxt    = mul_rsp.res;
          mul_req   = '{start: 1'b1, a: cfg.beta_bits, b: c_rdata};
          state_nxt = ST_TF_BM;
        end else if ((state_r == ST_TF_AM && mul_rsp.done) ||
                     (state_r == ST_TF_AW && add_rsp.done)) begin
          c_we    = 1'b1;
          c_wdata = (state_r == ST_TF_AM) ? mul_rsp.res : add_rsp.res;
          d_nxt   = FP_ZERO;
          state_nxt = k0 ? ST_TF_RD : ST_TL_RD;
          if (!i_end) begin
            i_nxt = i_r + DW'(1);
          end else begin
            i_nxt = '0;
            if (j_end) state_nxt = ST_DONE;
            else j_nxt = j_r + DW'(1);
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rd_in_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_in_r <= rd_in_nxt;
    end
    i_r  <= i_nxt;
    j_r  <= j_nxt;
    l_r  <= l_nxt;
    t_r  <= t_nxt;
    c_r  <= c_nxt;
    d_r  <= d_nxt;
    ad_r <= ad_nxt;
  end

  fmm_ram #(.AW(AW)) u_a_ram (
    .clk(clk), .we(a_we), .waddr(in_addr), .wdata(in_elem_value),
    .re(a_re), .raddr(a_raddr), .rdata(a_rdata)
  );

  fmm_ram #(.AW(AW)) u_b_ram (
    .clk(clk), .we(b_we), .waddr(in_addr), .wdata(in_elem_value),
    .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
  );

  fmm_ram #(.AW(AW)) u_c_ram (
    .clk(clk), .we(c_we), .waddr(c_addr), .wdata(c_wdata),
    .re(c_re), .raddr(c_addr), .rdata(c_rdata)
  );

  fmm_fmul u_fmul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));

  fmm_fadd u_fadd (.clk(clk), .rst_n(rst_n), .req(add_req), .rsp(add_rsp));

endmodule

`default_nettype wire

// ----- hdl/fmm_checker.sv -----
`default_nettype none

module fmm_checker import fmm_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  in_req_type,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_result_kind,
  input logic [31:0] out_read_value
);

  // hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_read_value) && $stable(out_result_kind))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_DONE) |-> out_read_value == 32'd0)
    else $error("compute completion carries data");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && ((in_req_type == REQ_COMPUTE) || (in_req_type == REQ_RD_C))
    |=> in_stall)
    else $error("block took a transaction while answering the previous one");

endmodule

bind float_matrix_multiply_accumulate fmm_checker u_fmm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_req_type    (in_req_type),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_result_kind(out_result_kind),
  .out_read_value (out_read_value)
);

`default_nettype wire

// ----- tb/float_mma_check.sv -----
`timescale 1ns / 1ps

module float_mma_check import fmm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [5:0]  in_row_index,
  input  logic [5:0]  in_col_index,
  input  logic [31:0] in_elem_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_result_kind,
  input  logic [31:0] out_read_value,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          errors,
  output int          pending,
  output int          done_seen,
  output int          reads_seen
);

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
  } answer_t;

  answer_t     answers[$];
  logic [31:0] a_mem[4096];
  logic [31:0] b_mem[4096];
  logic [31:0] c_mem[4096];

  logic        ta, tb;
  logic [6:0]  dim_m, dim_n, dim_k;
  logic [31:0] alpha, beta;

  assign pending = answers.size();

  initial begin
    errors     = 0;
    done_seen  = 0;
    reads_seen = 0;
    for (int i = 0; i < 4096; i++) begin
      a_mem[i] = FP_ZERO;
      b_mem[i] = FP_ZERO;
      c_mem[i] = FP_ZERO;
    end
  end

  function automatic logic is_nan(input logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 0;
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] == 0;
  endfunction

  // IEEE zero test: both signed zeros count, NaN does not
  function automatic logic is_zero(input logic [31:0] x);
    return x[30:0] == 0;
  endfunction

  function automatic real to_real(input logic [31:0] x);
    real r;
    if (x[30:23] == 8'hFF) return $bitstoreal({x[31], 11'h7FF, 52'd0});
    if (x[30:0] == 0) return $bitstoreal({x[31], 63'd0});
    if (x[30:23] == 0) begin
      r = real'(x[22:0]) * (2.0 ** (-149));
      return x[31] ? -r : r;
    end
    return $bitstoreal({x[31], 11'(x[30:23]) + 11'd896, x[22:0], 29'd0});
  endfunction

  // Round a double (exact product or sum of two singles) to single, nearest-even
  function automatic logic [31:0] to_single(input real r);
    logic [63:0] d, mant, q, rest, half;
    int          fe, sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) return {d[63], 8'hFF, 23'd0};
    if (d[62:52] == 0) return {d[63], 31'd0};
    fe   = int'(d[62:52]) - 896;
    mant = {11'd0, 1'b1, d[51:0]};
    sh   = (fe >= 1) ? 29 : 30 - fe;
    if (sh >= 60) return {d[63], 31'd0};
    q    = mant >> sh;
    rest = mant & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rest > half || (rest == half && q[0])) q = q + 64'd1;
    if (fe < 1) return {d[63], q[30:0]};
    if (q[24]) begin
      q  = q >> 1;
      fe = fe + 1;
    end
    if (fe >= 255) return {d[63], 8'hFF, 23'd0};
    return {d[63], fe[7:0], q[22:0]};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] x, input logic [31:0] y);
    if (is_nan(x)) return x | FP_QUIET;
    if (is_nan(y)) return y | FP_QUIET;
    if ((is_inf(x) && is_zero(y)) || (is_zero(x) && is_inf(y))) return FP_DEF_NAN;
    return to_single(to_real(x) * to_real(y));
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
    if (is_nan(x)) return x | FP_QUIET;
    if (is_nan(y)) return y | FP_QUIET;
    if (is_inf(x) && is_inf(y) && x[31] != y[31]) return FP_DEF_NAN;
    return to_single(to_real(x) + to_real(y));
  endfunction

  function automatic logic [31:0] b_elem(input int l, input int j);
    return tb ? b_mem[j * 64 + l] : b_mem[l * 64 + j];
  endfunction

  task automatic run_gemm();
    int          mm, nn, kk;
    logic [31:0] bv, t, d;
    mm = (dim_m > 64) ? 64 : dim_m;
    nn = (dim_n > 64) ? 64 : dim_n;
    kk = (dim_k > 64) ? 64 : dim_k;
    if (mm == 0 || nn == 0 || ((is_zero(alpha) || kk == 0) && beta == FP_ONE)) return;
    if (is_zero(alpha)) begin
      for (int j = 0; j < nn; j++)
        for (int i = 0; i < mm; i++)
          c_mem[i * 64 + j] = is_zero(beta) ? FP_ZERO : fp_mul(c_mem[i * 64 + j], beta);
      return;
    end
    for (int j = 0; j < nn; j++) begin
      if (!ta) begin
        for (int i = 0; i < mm; i++) begin
          if (is_zero(beta)) c_mem[i * 64 + j] = FP_ZERO;
          else if (beta != FP_ONE) c_mem[i * 64 + j] = fp_mul(c_mem[i * 64 + j], beta);
        end
        for (int l = 0; l < kk; l++) begin
          bv = b_elem(l, j);
          if (!is_zero(bv)) begin
            t = fp_mul(alpha, bv);
            for (int i = 0; i < mm; i++)
              c_mem[i * 64 + j] = fp_add(c_mem[i * 64 + j], fp_mul(t, a_mem[i * 64 + l]));
          end
        end
      end else begin
        for (int i = 0; i < mm; i++) begin
          d = FP_ZERO;
          for (int l = 0; l < kk; l++) d = fp_add(d, fp_mul(a_mem[l * 64 + i], b_elem(l, j)));
          if (is_zero(beta)) c_mem[i * 64 + j] = fp_mul(alpha, d);
          else c_mem[i * 64 + j] = fp_add(fp_mul(alpha, d), fp_mul(beta, c_mem[i * 64 + j]));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    answer_t want;
    int      idx;
    if (!rst_n) begin
      ta    = 1'b0;
      tb    = 1'b0;
      dim_m = '0;
      dim_n = '0;
      dim_k = '0;
      alpha = FP_ONE;
      beta  = FP_ZERO;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[4:2]))
          REG_TRANS_A: ta    = cfg_pwdata[0];
          REG_TRANS_B: tb    = cfg_pwdata[0];
          REG_ROWS_M:  dim_m = cfg_pwdata[6:0];
          REG_COLS_N:  dim_n = cfg_pwdata[6:0];
          REG_INNER_K: dim_k = cfg_pwdata[6:0];
          REG_ALPHA:   alpha = cfg_pwdata;
          REG_BETA:    beta  = cfg_pwdata;
          default: ;
        endcase
      end
      // retire results before taking new transactions
      if (out_valid && !out_stall) begin
        if (answers.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: kind %0d value %h", out_result_kind, out_read_value);
        end else begin
          want = answers.pop_front();
          if (out_result_kind === KIND_READ) reads_seen++;
          else done_seen++;
          if (want.kind !== out_result_kind || want.value !== out_read_value) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected kind %0d value %h, got kind %0d value %h",
                       want.kind, want.value, out_result_kind, out_read_value);
          end
        end
      end
      if (in_valid && !in_stall) begin
        idx = in_row_index * 64 + in_col_index;
        case (req_t'(in_req_type))
          REQ_WR_A:    a_mem[idx] = in_elem_value;
          REQ_WR_B:    b_mem[idx] = in_elem_value;
          REQ_WR_C:    c_mem[idx] = in_elem_value;
          REQ_COMPUTE: begin
            run_gemm();
            answers.push_back({KIND_DONE, FP_ZERO});
          end
          REQ_RD_C:    answers.push_back({KIND_READ, c_mem[idx]});
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- tb/float_matrix_multiply_accumulate_test.sv -----
`timescale 1ns / 1ps

module float_matrix_multiply_accumulate_test import fmm_pkg::*;;

  localparam int LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_req_type = REQ_WR_A;
  logic [5:0]  in_row_index = '0;
  logic [5:0]  in_col_index = '0;
  logic [31:0] in_elem_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_result_kind;
  logic [31:0] out_read_value;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int errors, pending, done_seen, reads_seen;
  int cycles = 0;
  int sent = 0;
  int send_idle = 0;
  int stall_pct = 0;
  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;

  // which stored elements have been loaded, so no unwritten entry is ever read
  bit a_set[4096];
  bit b_set[4096];
  bit c_set[4096];
  int c_list[$];
  int cur_m, cur_n, cur_k;
  bit cur_ta, cur_tb;

  always #6 clk = ~clk;

  float_matrix_multiply_accumulate DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_row_index(in_row_index), .in_col_index(in_col_index), .in_elem_value(in_elem_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_result_kind(out_result_kind),
    .out_read_value(out_read_value),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  float_mma_check gemm_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_row_index(in_row_index), .in_col_index(in_col_index), .in_elem_value(in_elem_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_result_kind(out_result_kind),
    .out_read_value(out_read_value),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .errors(errors), .pending(pending), .done_seen(done_seen), .reads_seen(reads_seen)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: a long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [31:0] rand_float();
    logic s;
    s = $urandom_range(1);
    case ($urandom_range(39))
      0: return FP_ZERO;
      1: return 32'h8000_0000;
      2: return {s, 8'hFF, 23'd0};
      3: return {s, 8'hFF, 23'($urandom) | 23'd1};
      4: return {s, 8'd0, 23'($urandom)};
      5: return $urandom;
      6: return {s, 8'hFE, 23'($urandom)};
      7: return FP_ONE;
      default: return {s, 8'($urandom_range(118, 136)), 23'($urandom)};
    endcase
  endfunction

  task automatic send(input logic [2:0] req, input int row, input int col,
                      input logic [31:0] value);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_row_index  <= row[5:0];
    in_col_index  <= col[5:0];
    in_elem_value <= value;
    do @(posedge clk); while (in_stall);
    sent++;
    if (req_t'(req) == REQ_WR_C && !c_set[row * 64 + col]) begin
      c_set[row * 64 + col] = 1'b1;
      c_list.push_back(row * 64 + col);
    end
    if (req_t'(req) == REQ_WR_A) a_set[row * 64 + col] = 1'b1;
    if (req_t'(req) == REQ_WR_B) b_set[row * 64 + col] = 1'b1;
  endtask

  // drop valid and wait for every answer, then let a trailing compute drain
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input bit ta, input bit tb, input int m, input int n, input int k,
                           input logic [31:0] alpha, input logic [31:0] beta);
    reg_write(REG_TRANS_A, {31'd0, ta});
    reg_write(REG_TRANS_B, {31'd0, tb});
    reg_write(REG_ROWS_M, m);
    reg_write(REG_COLS_N, n);
    reg_write(REG_INNER_K, k);
    reg_write(REG_ALPHA, alpha);
    reg_write(REG_BETA, beta);
    cur_ta = ta;
    cur_tb = tb;
    cur_m  = (m > 64) ? 64 : m;
    cur_n  = (n > 64) ? 64 : n;
    cur_k  = (k > 64) ? 64 : k;
  endtask

  // load every operand the update may touch, then run it
  task automatic compute();
    int ra, ca, rb, cb;
    ra = cur_ta ? cur_k : cur_m;
    ca = cur_ta ? cur_m : cur_k;
    rb = cur_tb ? cur_n : cur_k;
    cb = cur_tb ? cur_k : cur_n;
    for (int r = 0; r < ra; r++)
      for (int c = 0; c < ca; c++)
        if (!a_set[r * 64 + c]) send(REQ_WR_A, r, c, rand_float());
    for (int r = 0; r < rb; r++)
      for (int c = 0; c < cb; c++)
        if (!b_set[r * 64 + c]) send(REQ_WR_B, r, c, rand_float());
    for (int r = 0; r < cur_m; r++)
      for (int c = 0; c < cur_n; c++)
        if (!c_set[r * 64 + c]) send(REQ_WR_C, r, c, rand_float());
    send(REQ_COMPUTE, $urandom_range(63), $urandom_range(63), $urandom);
  endtask

  task automatic read_some_c();
    int idx;
    if (c_list.size() == 0) begin
      send(REQ_RD_C, 0, 0, $urandom);
      return;
    end
    idx = c_list[$urandom_range(c_list.size() - 1)];
    send(REQ_RD_C, idx / 64, idx % 64, $urandom);
  endtask

  task automatic run_items(input int count);
    int pick, sel, rows, cols;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        sel  = $urandom_range(2);
        rows = (sel == 0) ? (cur_ta ? cur_k : cur_m) : (sel == 1) ? (cur_tb ? cur_n : cur_k) : cur_m;
        cols = (sel == 0) ? (cur_ta ? cur_m : cur_k) : (sel == 1) ? (cur_tb ? cur_k : cur_n) : cur_n;
        if (rows == 0) rows = 64;
        if (cols == 0) cols = 64;
        send(3'(sel), $urandom_range(rows - 1), $urandom_range(cols - 1), rand_float());
      end else if (pick < 52) begin
        send(3'($urandom_range(2)), $urandom_range(63), $urandom_range(63), $urandom);
      end else if (pick < 64) begin
        compute();
      end else if (pick < 95) begin
        read_some_c();
      end else begin
        send(3'($urandom_range(5, 7)), $urandom_range(63), $urandom_range(63), $urandom);
      end
    end
  endtask

  task automatic set_pace(input int mode);
    case (mode % 4)
      0: begin send_idle = 0;  stall_pct = 0;  end
      1: begin send_idle = 75; stall_pct = 0;  end
      2: begin send_idle = 0;  stall_pct = 75; end
      default: begin send_idle = 10; stall_pct = 10; end
    endcase
  endtask

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(9))
      0: return FP_ZERO;
      1: return 32'h8000_0000;
      2: return FP_ONE;
      3: return 32'h4020_0000;
      4: return 32'hBF00_0000;
      5: return rand_float();
      default: return {1'($urandom_range(1)), 8'($urandom_range(124, 129)), 23'($urandom)};
    endcase
  endfunction

  initial begin
    int phase;
    int m, n, k;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration has empty dimensions: compute just answers
    send(REQ_COMPUTE, 0, 0, 32'h0);
    send(REQ_WR_C, 0, 0, 32'hFFFF_FFFF);
    send(REQ_WR_C, 63, 63, FP_ZERO);
    send(REQ_WR_A, 63, 63, 32'hFFFF_FFFF);
    send(REQ_WR_B, 0, 63, FP_ZERO);
    send(REQ_RD_C, 63, 63, 32'hFFFF_FFFF);
    send(REQ_RD_C, 0, 0, FP_ZERO);
    send(3'd5, 63, 0, 32'hFFFF_FFFF);
    send(3'd6, 0, 63, FP_ZERO);
    send(3'd7, 63, 63, 32'hA5A5_5A5A);
    send(REQ_COMPUTE, 63, 63, 32'hFFFF_FFFF);
    send(REQ_RD_C, 0, 0, 32'h0);
    drain();

    // special scalings, transposes, NaN scale, and the size extremes
    configure(0, 0, 3, 2, 2, FP_ZERO, FP_ONE);      compute(); read_some_c(); drain();
    configure(0, 0, 3, 2, 2, FP_ZERO, FP_ZERO);     compute(); read_some_c(); drain();
    configure(1, 0, 3, 2, 2, 32'h8000_0000, 32'h4020_0000); compute(); read_some_c(); drain();
    configure(0, 1, 2, 3, 0, 32'h4000_0000, 32'h3F00_0000); compute(); read_some_c(); drain();
    configure(1, 1, 2, 2, 3, FP_ONE, FP_ONE);       compute(); read_some_c(); drain();
    configure(0, 0, 2, 2, 2, 32'h7FC0_1234, FP_ZERO); compute(); read_some_c(); drain();
    configure(0, 0, 64, 1, 1, FP_ONE, FP_ONE);      compute(); read_some_c(); drain();
    configure(1, 1, 1, 127, 2, 32'h3FC0_0000, FP_ZERO); compute(); read_some_c(); drain();
    configure(1, 0, 2, 1, 100, FP_ONE, 32'hC000_0000); compute(); read_some_c(); drain();
    configure(0, 0, 0, 5, 3, FP_ONE, FP_ZERO);      compute(); drain();

    // hold the result side while reads keep arriving, so the input backs up
    set_pace(0);
    hold_go <= ~hold_go;
    for (int i = 0; i < 40; i++) read_some_c();
    drain();

    phase = 0;
    while (sent < 1450) begin
      set_pace(phase);
      case ($urandom_range(9))
        0: begin m = $urandom_range(1, 2); n = 1; k = 64; end
        1: begin m = 1; n = $urandom_range(65, 127); k = 1; end
        2: begin m = $urandom_range(0, 3); n = $urandom_range(0, 3); k = 0; end
        default: begin
          m = $urandom_range(1, 4);
          n = $urandom_range(1, 4);
          k = $urandom_range(1, 4);
        end
      endcase
      configure($urandom_range(1), $urandom_range(1), m, n, k, rand_scale(), rand_scale());
      run_items($urandom_range(30, 60));
      compute();
      read_some_c();
      drain();
      phase++;
    end
    set_pace(0);
    configure(0, 0, 0, 0, 0, FP_ONE, FP_ZERO);

    drain();
    $display("sent %0d transactions over %0d configurations", sent, phase + 11);
    $display("checked %0d compute completions and %0d element reads", done_seen, reads_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
